[hw/rtl/pvlt_pkg.sv]
// Package for the packed value list table: field widths, request and
// status codes, and the result record passed from the sequencer to the top.
// No dependencies.
package pvlt_pkg;

  localparam int DATA_W           = 32;
  localparam int ACTION_W         = 2;
  localparam int STATUS_W         = 2;
  localparam int POS_W            = 7;
  localparam int FILL_W           = 8;
  localparam int CAPACITY_DEFAULT = 128;

  // Request kinds carried in the action field.
  typedef enum logic [ACTION_W-1:0] {
    ACT_ADD    = 2'd0,
    ACT_SEARCH = 2'd1,
    ACT_UPDATE = 2'd2,
    ACT_DELETE = 2'd3
  } action_t;

  // Outcome codes carried in the status field.
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2
  } status_t;

  // One finished result, as handed to the output register.
  typedef struct packed {
    status_t            status;
    logic [POS_W-1:0]   position;
    logic [FILL_W-1:0]  fill_count;
  } result_t;

endpackage

[hw/rtl/pvlt_if.sv]
// Valid/ready channel interfaces for the request and result beats.
// Depends on pvlt_pkg for the field widths.

interface pvlt_req_if;
  import pvlt_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [ACTION_W-1:0]        action;
  logic signed [DATA_W-1:0]   key;
  logic signed [DATA_W-1:0]   replacement;

  modport source (output valid, output action, output key, output replacement,
                  input ready);
  modport sink   (input valid, input action, input key, input replacement,
                  output ready);
endinterface

interface pvlt_rsp_if;
  import pvlt_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [STATUS_W-1:0]   status;
  logic [POS_W-1:0]      position;
  logic [FILL_W-1:0]     fill_count;

  modport source (output valid, output status, output position, output fill_count,
                  input ready);
  modport sink   (input valid, input status, input position, input fill_count,
                  output ready);
endinterface

[hw/rtl/pvlt_mem.sv]
// Entry store of the value list: one write port and one read port with
// registered read data. Depends on pvlt_pkg for the data width.
module pvlt_mem #(
  parameter int ADDR_W = 7
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [ADDR_W-1:0]             waddr,
  input  logic [pvlt_pkg::DATA_W-1:0]   wdata,
  input  logic [ADDR_W-1:0]             raddr,
  output logic [pvlt_pkg::DATA_W-1:0]   rdata
);
  import pvlt_pkg::*;

  localparam int Depth = 1 << ADDR_W;

  logic [DATA_W-1:0] store [Depth];

  // Write port; entries hold no reset value.
  always_ff @(posedge clk) begin
    if (we) begin
      store[waddr] <= wdata;
    end
  end

  // Read port with the data registered.
  always_ff @(posedge clk) begin
    rdata <= store[raddr];
  end

endmodule

[hw/rtl/pvlt_ctrl.sv]
// Sequencer of the value list: takes a request, walks the entries through the
// single read port and shared comparator, shifts entries down on delete.
// Depends on pvlt_pkg and pvlt_if.
module pvlt_ctrl #(
  parameter int CAPACITY = pvlt_pkg::CAPACITY_DEFAULT,
  parameter int IDX_W    = 7
) (
  input  logic                          clk,
  input  logic                          rst,
  pvlt_req_if.sink                      req,
  output logic                          res_valid,
  input  logic                          res_taken,
  output pvlt_pkg::result_t             res,
  output logic                          mem_we,
  output logic [IDX_W-1:0]              mem_waddr,
  output logic [pvlt_pkg::DATA_W-1:0]   mem_wdata,
  output logic [IDX_W-1:0]              mem_raddr,
  input  logic [pvlt_pkg::DATA_W-1:0]   mem_rdata
);
  import pvlt_pkg::*;

  localparam int CntW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_REPORT
  } state_t;

  state_t              state;
  logic [CntW-1:0]     count;
  logic [IDX_W-1:0]    idx;
  action_t             act;
  logic [DATA_W-1:0]   key;
  logic [DATA_W-1:0]   repl;
  status_t             res_status;
  logic [IDX_W-1:0]    res_pos;

  logic                in_fire;
  logic [CntW-1:0]     idx_ext;
  logic [CntW-1:0]     idx_inc;
  logic                match;
  logic                has_room;

  assign in_fire  = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign idx_ext  = CntW'(idx);
  assign idx_inc  = idx_ext + CntW'(1);
  assign match    = (mem_rdata == key);
  assign has_room = (count < CntW'(CAPACITY));

  assign res_valid      = (state == S_REPORT);
  assign res.status     = res_status;
  assign res.position   = POS_W'(res_pos);
  assign res.fill_count = FILL_W'(count);

  // Memory port control. The read address runs one entry ahead of the
  // entry whose data is being compared or moved.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx;
    mem_wdata = key;
    mem_raddr = idx + IDX_W'(1);
    unique case (state)
      S_IDLE: begin
        mem_raddr = '0;
        if (in_fire && action_t'(req.action) == ACT_ADD && has_room) begin
          mem_we    = 1'b1;
          mem_waddr = IDX_W'(count);
          mem_wdata = req.key;
        end
      end
      S_SCAN: begin
        if (match && act == ACT_UPDATE) begin
          mem_we    = 1'b1;
          mem_wdata = repl;
        end
      end
      S_SHIFT: begin
        mem_raddr = idx + IDX_W'(1) + IDX_W'(1);
        if (idx_inc < count) begin
          mem_we    = 1'b1;
          mem_wdata = mem_rdata;
        end
      end
      S_REPORT: begin
      end
      default: begin
      end
    endcase
  end

  // Sequencer state, fill count and the pending result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            act        <= action_t'(req.action);
            key        <= req.key;
            repl       <= req.replacement;
            idx        <= '0;
            res_status <= ST_DONE;
            res_pos    <= '0;
            if (action_t'(req.action) == ACT_ADD) begin
              if (has_room) begin
                res_pos <= IDX_W'(count);
                count   <= count + CntW'(1);
              end else begin
                res_status <= ST_FULL;
              end
              state <= S_REPORT;
            end else if (count == '0) begin
              res_status <= ST_MISSING;
              state      <= S_REPORT;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (match) begin
            res_pos <= idx;
            state   <= (act == ACT_DELETE) ? S_SHIFT : S_REPORT;
          end else if (idx_inc == count) begin
            res_status <= ST_MISSING;
            state      <= S_REPORT;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        S_SHIFT: begin
          if (idx_inc < count) begin
            idx <= idx + IDX_W'(1);
          end else begin
            count <= count - CntW'(1);
            state <= S_REPORT;
          end
        end
        S_REPORT: begin
          if (res_taken) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The fill count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(CAPACITY))
    else $error("fill count above capacity");

  // The scan only visits filled positions.
  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (idx_inc <= count))
    else $error("scan index beyond fill count");

  // An add with room grows the list by exactly one.
  a_add_grows: assert property (@(posedge clk) disable iff (rst)
    (in_fire && action_t'(req.action) == ACT_ADD && has_room)
      |=> (count == $past(count) + CntW'(1)))
    else $error("add did not raise the fill count");

  // The end of a delete shift lowers the count by one.
  a_delete_shrinks: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT && !(idx_inc < count)) |=> (count == $past(count) - CntW'(1)))
    else $error("delete did not lower the fill count");

endmodule

[hw/rtl/packed_value_list_table_core.sv]
// Top level of the packed value list table: entry store, sequencer and the
// output register. Depends on pvlt_pkg, pvlt_if, pvlt_mem and pvlt_ctrl.
//
//   Channel  Dir  Beat contents
//   req      in   action, key, replacement
//   rsp      out  status, position, fill_count
//
// Add and any request on an empty list go straight to the result, with no walk.
// Search, update and delete walk the entries up to a match or to the end of
// the list; a delete that matches then shifts the later entries down.
// The walk runs at one entry per cycle, set by the single store read port.
// Synchronous reset empties the list; the entry store itself is not cleared.
// req.ready is low from accept until the result enters the output register;
// a held result stalls the sequencer, not the request side beyond that.
module packed_value_list_table_core #(
  parameter int CAPACITY = pvlt_pkg::CAPACITY_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  pvlt_req_if.sink    req,
  pvlt_rsp_if.source  rsp
);
  import pvlt_pkg::*;

  localparam int IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic               res_valid;
  logic               res_taken;
  result_t            res;
  logic               mem_we;
  logic [IdxW-1:0]    mem_waddr;
  logic [DATA_W-1:0]  mem_wdata;
  logic [IdxW-1:0]    mem_raddr;
  logic [DATA_W-1:0]  mem_rdata;

  logic               out_valid;
  result_t            out_res;

  pvlt_mem #(
    .ADDR_W (IdxW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  pvlt_ctrl #(
    .CAPACITY (CAPACITY),
    .IDX_W    (IdxW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .res_valid (res_valid),
    .res_taken (res_taken),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // A result moves into the output register once that register is free or
  // is being emptied in the same cycle.
  assign res_taken = res_valid && (!out_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_taken) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_taken) begin
      out_res <= res;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.status     = out_res.status;
  assign rsp.position   = out_res.position;
  assign rsp.fill_count = out_res.fill_count;

endmodule
